### hw/rtl/ascii_to_hid_key_report_encoder_core_macros.svh
// Assertion macros shared by the HID report encoder RTL.
`ifndef ASCII_TO_HID_KEY_REPORT_ENCODER_CORE_MACROS_SVH
`define ASCII_TO_HID_KEY_REPORT_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off while reset is asserted.
`define A2H_ASSERT_IMP(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("a2h: same-cycle check failed");
// Next-cycle implication, held off while reset is asserted.
`define A2H_ASSERT_NXT(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("a2h: next-cycle check failed");
`else
`define A2H_ASSERT_IMP(label, clk_i, rstn_i, ante, cons)
`define A2H_ASSERT_NXT(label, clk_i, rstn_i, ante, cons)
`endif
`endif

### hw/rtl/a2h_pkg.sv
// Types, codes and key mapping for the ASCII to HID report encoder.
package a2h_pkg;

  typedef enum logic [0:0] {
    OP_CHAR = 1'b0,
    OP_LED  = 1'b1
  } op_t;

  // Position within one character's run of reports.
  typedef enum logic [1:0] {
    STEP_CAPS    = 2'd0,
    STEP_CAPS_UP = 2'd1,
    STEP_PRESS   = 2'd2,
    STEP_RELEASE = 2'd3
  } step_t;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  localparam logic [7:0] SHIFT_PREFIX_RESET = 8'hE1;
  localparam logic [7:0] CAPS_USAGE         = 8'h39;
  localparam logic [7:0] LSHIFT             = 8'h02;
  localparam logic [7:0] LOWER_OFFSET       = 8'h5D;
  localparam logic [7:0] UPPER_OFFSET       = 8'h3D;
  localparam logic [7:0] DIGIT_OFFSET       = 8'h13;
  localparam logic [7:0] ZERO_USAGE         = 8'h27;
  localparam logic [7:0] SPECIAL_OFFSET     = 8'h88;
  localparam int unsigned LED_CAPS_BIT      = 1;

  typedef struct packed {
    logic [7:0] mod;
    logic [7:0] key;
  } key_t;

  // One classified character waiting for the report sequencer.
  typedef struct packed {
    logic       caps_first;
    logic [7:0] mod;
    logic [7:0] key;
  } job_t;

  typedef struct packed {
    logic [7:0] mod;
    logic [7:0] key;
    logic       last;
  } report_t;

  function automatic key_t punct_map(input logic [7:0] c);
    key_t r;
    r = '{mod: 8'h00, key: 8'h00};
    case (c)
      8'h20: r.key = 8'h2C;
      8'h21: r = '{mod: LSHIFT, key: 8'h1E};
      8'h22: r = '{mod: LSHIFT, key: 8'h34};
      8'h23: r = '{mod: LSHIFT, key: 8'h20};
      8'h24: r = '{mod: LSHIFT, key: 8'h21};
      8'h25: r = '{mod: LSHIFT, key: 8'h22};
      8'h26: r = '{mod: LSHIFT, key: 8'h24};
      8'h27: r.key = 8'h34;
      8'h28: r = '{mod: LSHIFT, key: 8'h26};
      8'h29: r = '{mod: LSHIFT, key: 8'h27};
      8'h2A: r = '{mod: LSHIFT, key: 8'h25};
      8'h2B: r = '{mod: LSHIFT, key: 8'h2E};
      8'h2C: r.key = 8'h36;
      8'h2D: r.key = 8'h2D;
      8'h2E: r.key = 8'h37;
      8'h2F: r.key = 8'h38;
      8'h3A: r = '{mod: LSHIFT, key: 8'h33};
      8'h3B: r.key = 8'h33;
      8'h3C: r = '{mod: LSHIFT, key: 8'h36};
      8'h3D: r.key = 8'h2E;
      8'h3E: r = '{mod: LSHIFT, key: 8'h37};
      8'h3F: r = '{mod: LSHIFT, key: 8'h38};
      8'h40: r = '{mod: LSHIFT, key: 8'h1F};
      8'h5B: r.key = 8'h2F;
      8'h5C: r.key = 8'h31;
      8'h5D: r.key = 8'h30;
      8'h5E: r = '{mod: LSHIFT, key: 8'h23};
      8'h5F: r = '{mod: LSHIFT, key: 8'h2D};
      8'h60: r.key = 8'h35;
      8'h7B: r = '{mod: LSHIFT, key: 8'h2F};
      8'h7C: r = '{mod: LSHIFT, key: 8'h31};
      8'h7D: r = '{mod: LSHIFT, key: 8'h30};
      8'h7E: r = '{mod: LSHIFT, key: 8'h35};
      8'h7F: r.key = 8'h4C;
      default: r = '{mod: 8'h00, key: 8'h00};
    endcase
    return r;
  endfunction

  function automatic key_t key_map(input logic [7:0] c);
    key_t r;
    r = '{mod: 8'h00, key: 8'h00};
    if (c inside {[8'h61:8'h7A]}) begin
      r.key = c - LOWER_OFFSET;
    end else if (c inside {[8'h41:8'h5A]}) begin
      r.key = c - UPPER_OFFSET;
    end else if (c inside {[8'h31:8'h39]}) begin
      r.key = c - DIGIT_OFFSET;
    end else if (c == 8'h30) begin
      r.key = ZERO_USAGE;
    end else if (c inside {[8'h80:8'h87]}) begin
      r.mod = 8'h01 << c[2:0];
    end else if (c inside {[8'hB0:8'hB3], [8'hC1:8'hCD], [8'hD1:8'hD5], [8'hD7:8'hDA]}) begin
      r.key = c - SPECIAL_OFFSET;
    end else begin
      r = punct_map(c);
    end
    return r;
  endfunction

  function automatic report_t report_for(input job_t j, input step_t s);
    report_t r;
    r = '{mod: 8'h00, key: 8'h00, last: 1'b0};
    case (s)
      STEP_CAPS:    r.key = CAPS_USAGE;
      STEP_CAPS_UP: r.key = 8'h00;
      STEP_PRESS: begin
        r.mod = j.mod;
        r.key = j.key;
      end
      STEP_RELEASE: r.last = 1'b1;
      default:      r.last = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/ascii_to_hid_key_report_encoder_core.sv
// Top level of the ASCII to HID keyboard report encoder.
//
//   channel  direction  handshake           payload
//   in_      input      in_push / in_full   in_op, in_char_code, in_led_bits
//   out_     output     out_pop / out_empty out_modifier_bits, out_key_usage, out_last
//   cfg_     input      cfg_wr_en           cfg_wr_data (shift prefix code)
//
// A character leaves as 2 reports, or 4 when a caps-lock toggle goes first, one report
// per cycle from the sequencer and its output register while out_pop keeps up.
// LED items and the shift prefix are taken on the input and produce no report.
// A character's first report is held in the job queue, then in the output register.
// in_full rises while the job queue holds QUEUE_DEPTH characters.
// Synchronous active-low reset: prefix code 0xE1, caps lock clear, queue and output empty.
module ascii_to_hid_key_report_encoder_core
  import a2h_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_op,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_led_bits,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_modifier_bits,
  output logic [7:0] out_key_usage,
  output logic       out_last
);

  logic q_wr_en;
  job_t q_wr_data;
  logic q_full;
  logic q_rd_en;
  job_t q_rd_data;
  logic q_empty;

  a2h_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_op        (in_op),
    .in_char_code (in_char_code),
    .in_led_bits  (in_led_bits),
    .q_full       (q_full),
    .q_wr_en      (q_wr_en),
    .q_wr_data    (q_wr_data)
  );

  a2h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  a2h_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_rd_data         (q_rd_data),
    .q_rd_en           (q_rd_en),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_modifier_bits (out_modifier_bits),
    .out_key_usage     (out_key_usage),
    .out_last          (out_last)
  );

endmodule

### hw/rtl/a2h_front.sv
// Front end: takes items, tracks caps lock and the prefix code, classifies characters.
module a2h_front
  import a2h_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_op,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_led_bits,
  input  logic       q_full,
  output logic       q_wr_en,
  output job_t       q_wr_data
);

  logic [7:0] shift_prefix_r;
  logic [7:0] shift_prefix_nxt;
  logic       caps_lit_r;
  logic       caps_lit_nxt;
  logic       accept;
  logic       is_lower;
  logic       is_upper;
  key_t       mapped;

  assign in_full  = q_full;
  assign accept   = in_push && !in_full;
  assign is_lower = in_char_code inside {[8'h61:8'h7A]};
  assign is_upper = in_char_code inside {[8'h41:8'h5A]};
  assign mapped   = key_map(in_char_code);

  always_comb begin
    shift_prefix_nxt = cfg_wr_en ? cfg_wr_data : shift_prefix_r;
    caps_lit_nxt     = caps_lit_r;
    if (accept && (in_op == OP_LED)) begin
      caps_lit_nxt = in_led_bits[LED_CAPS_BIT];
    end
  end

  // Drop LED items and the shift prefix; everything else becomes one job.
  always_comb begin
    q_wr_en              = accept && (in_op == OP_CHAR) && (in_char_code != shift_prefix_r);
    q_wr_data.caps_first = (is_lower && caps_lit_r) || (is_upper && !caps_lit_r);
    q_wr_data.mod        = mapped.mod;
    q_wr_data.key        = mapped.key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_prefix_r <= SHIFT_PREFIX_RESET;
      caps_lit_r     <= 1'b0;
    end else begin
      shift_prefix_r <= shift_prefix_nxt;
      caps_lit_r     <= caps_lit_nxt;
    end
  end

endmodule

### hw/rtl/a2h_queue.sv
// Short job queue between the classifier and the report sequencer.
`include "ascii_to_hid_key_report_encoder_core_macros.svh"
module a2h_queue
  import a2h_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `A2H_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, wr_en, !full)
  `A2H_ASSERT_IMP(a_queue_no_underflow, clk, rst_n, rd_en, !empty)
  `A2H_ASSERT_IMP(a_queue_count_in_range, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))

endmodule

### hw/rtl/a2h_back.sv
// Back end: steps each job through its reports into the output register.
`include "ascii_to_hid_key_report_encoder_core_macros.svh"
module a2h_back
  import a2h_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_rd_data,
  output logic       q_rd_en,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_modifier_bits,
  output logic [7:0] out_key_usage,
  output logic       out_last
);

  back_state_t state_r;
  back_state_t state_nxt;
  step_t       step_r;
  step_t       step_nxt;
  job_t        job_r;
  job_t        job_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  report_t     out_rpt_r;
  report_t     out_rpt_nxt;
  logic        load;
  logic        emit;
  step_t       emit_step;
  job_t        emit_job;

  // The output register takes a new report when it is empty or being transferred.
  assign load = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (load && !q_empty) state_nxt = BK_RUN;
      BK_RUN:  if (load && (step_r == STEP_RELEASE)) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_rd_en   = 1'b0;
    emit      = 1'b0;
    emit_step = step_r;
    emit_job  = job_r;
    case (state_r)
      BK_IDLE: begin
        q_rd_en   = load && !q_empty;
        emit      = q_rd_en;
        emit_job  = q_rd_data;
        emit_step = q_rd_data.caps_first ? STEP_CAPS : STEP_PRESS;
      end
      BK_RUN: begin
        emit = load;
      end
      default: emit = 1'b0;
    endcase
    job_nxt       = emit ? emit_job : job_r;
    step_nxt      = emit ? step_t'(emit_step + 2'd1) : step_r;
    out_valid_nxt = load ? emit : out_valid_r;
    out_rpt_nxt   = (load && emit) ? report_for(emit_job, emit_step) : out_rpt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= STEP_CAPS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    out_rpt_r <= out_rpt_nxt;
  end

  assign out_empty         = !out_valid_r;
  assign out_modifier_bits = out_rpt_r.mod;
  assign out_key_usage     = out_rpt_r.key;
  assign out_last          = out_rpt_r.last;

  `A2H_ASSERT_IMP(a_run_has_report, clk, rst_n, state_r == BK_RUN, out_valid_r)
  `A2H_ASSERT_NXT(a_take_shows_report, clk, rst_n, q_rd_en, out_valid_r)
  `A2H_ASSERT_IMP(a_release_is_blank, clk, rst_n, out_valid_r && out_rpt_r.last,
                  (out_rpt_r.mod == 8'h00) && (out_rpt_r.key == 8'h00))

endmodule

### dv/tb.sv
// Self-checking testbench for the ASCII to HID keyboard report encoder.
module tb;
  import a2h_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_TAIL   = 16;
  localparam int DIR_ROWS    = 25;
  localparam int PHASE_ITEMS = 24;

  typedef report_t [3:0] run_t;

  // One input item, with an optional typed-in press report and result count.
  typedef struct packed {
    op_t        op;
    logic [7:0] code;
    logic [7:0] leds;
    logic       lit;
    logic [2:0] lit_n;
    logic [7:0] lit_mod;
    logic [7:0] lit_key;
  } stim_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_push = 1'b0;
  logic       in_full;
  logic       in_op = OP_CHAR;
  logic [7:0] in_char_code = 8'h00;
  logic [7:0] in_led_bits = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_modifier_bits;
  logic [7:0] out_key_usage;
  logic       out_last;

  // Typed-in expectation travelling with the item on the input channel
  logic       lit_valid = 1'b0;
  logic [2:0] lit_n = 3'd0;
  logic [7:0] lit_mod = 8'h00;
  logic [7:0] lit_key = 8'h00;

  logic [7:0] prefix_model;
  logic       caps_model;
  report_t    awaited_reports[$];
  int         mismatches = 0;
  int         cycles = 0;
  int         pop_hold = 0;
  int         pop_calm = 0;
  int         push_calm = 0;
  stim_t      dir_rows [0:DIR_ROWS-1];

  ascii_to_hid_key_report_encoder_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_op             (in_op),
    .in_char_code      (in_char_code),
    .in_led_bits       (in_led_bits),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_modifier_bits (out_modifier_bits),
    .out_key_usage     (out_key_usage),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  // Press report for a byte: {modifier, usage}
  function automatic logic [15:0] press_for(input logic [7:0] c);
    logic [15:0] v;
    v = 16'h0000;
    if (c >= 8'h61 && c <= 8'h7A) begin
      v = {8'h00, 8'(c - LOWER_OFFSET)};
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = {8'h00, 8'(c - UPPER_OFFSET)};
    end else if (c >= 8'h31 && c <= 8'h39) begin
      v = {8'h00, 8'(c - DIGIT_OFFSET)};
    end else if (c == 8'h30) begin
      v = {8'h00, ZERO_USAGE};
    end else if (c >= 8'h80 && c <= 8'h87) begin
      v = {8'(8'h01 << (c - 8'h80)), 8'h00};
    end else if ((c >= 8'hB0 && c <= 8'hB3) || (c >= 8'hC1 && c <= 8'hCD) ||
                 (c >= 8'hD1 && c <= 8'hD5) || (c >= 8'hD7 && c <= 8'hDA)) begin
      v = {8'h00, 8'(c - SPECIAL_OFFSET)};
    end else begin
      case (c)
        8'h20: v = 16'h002C;
        8'h21: v = {LSHIFT, 8'h1E};
        8'h22: v = {LSHIFT, 8'h34};
        8'h23: v = {LSHIFT, 8'h20};
        8'h24: v = {LSHIFT, 8'h21};
        8'h25: v = {LSHIFT, 8'h22};
        8'h26: v = {LSHIFT, 8'h24};
        8'h27: v = 16'h0034;
        8'h28: v = {LSHIFT, 8'h26};
        8'h29: v = {LSHIFT, 8'h27};
        8'h2A: v = {LSHIFT, 8'h25};
        8'h2B: v = {LSHIFT, 8'h2E};
        8'h2C: v = 16'h0036;
        8'h2D: v = 16'h002D;
        8'h2E: v = 16'h0037;
        8'h2F: v = 16'h0038;
        8'h3A: v = {LSHIFT, 8'h33};
        8'h3B: v = 16'h0033;
        8'h3C: v = {LSHIFT, 8'h36};
        8'h3D: v = 16'h002E;
        8'h3E: v = {LSHIFT, 8'h37};
        8'h3F: v = {LSHIFT, 8'h38};
        8'h40: v = {LSHIFT, 8'h1F};
        8'h5B: v = 16'h002F;
        8'h5C: v = 16'h0031;
        8'h5D: v = 16'h0030;
        8'h5E: v = {LSHIFT, 8'h23};
        8'h5F: v = {LSHIFT, 8'h2D};
        8'h60: v = 16'h0035;
        8'h7B: v = {LSHIFT, 8'h2F};
        8'h7C: v = {LSHIFT, 8'h31};
        8'h7D: v = {LSHIFT, 8'h30};
        8'h7E: v = {LSHIFT, 8'h35};
        8'h7F: v = 16'h004C;
        default: v = 16'h0000;
      endcase
    end
    return v;
  endfunction

  // Reports caused by one item; updates the caps-lock copy on LED items
  function automatic int encode_item(input op_t op, input logic [7:0] c,
                                     input logic [7:0] leds, output run_t reps);
    logic        lower;
    logic        upper;
    logic [15:0] pk;
    int          n;
    reps  = '0;
    n     = 0;
    lower = (c >= 8'h61 && c <= 8'h7A);
    upper = (c >= 8'h41 && c <= 8'h5A);
    if (op == OP_LED) begin
      caps_model = leds[LED_CAPS_BIT];
      return 0;
    end
    if (c == prefix_model) return 0;
    // Toggle caps lock first when the letter's case disagrees with the LED
    if ((lower && caps_model) || (upper && !caps_model)) begin
      reps[0] = '{mod: 8'h00, key: CAPS_USAGE, last: 1'b0};
      reps[1] = '{mod: 8'h00, key: 8'h00, last: 1'b0};
      n = 2;
    end
    pk = press_for(c);
    reps[n]   = '{mod: pk[15:8], key: pk[7:0], last: 1'b0};
    reps[n+1] = '{mod: 8'h00, key: 8'h00, last: 1'b1};
    return n + 2;
  endfunction

  // Model the register, record expectations and check every result transfer
  always @(posedge clk) begin : scoreboard
    run_t    reps;
    report_t want;
    int      n;
    int      k;
    if (!rst_n) begin
      prefix_model = SHIFT_PREFIX_RESET;
      caps_model   = 1'b0;
    end else begin
      if (cfg_wr_en) prefix_model = cfg_wr_data;
      if (in_push && !in_full) begin
        n = encode_item(op_t'(in_op), in_char_code, in_led_bits, reps);
        if (lit_valid) begin
          n    = int'(lit_n);
          reps = '0;
          k    = 0;
          if (lit_n == 3'd4) begin
            reps[0] = '{mod: 8'h00, key: CAPS_USAGE, last: 1'b0};
            k = 2;
          end
          if (lit_n != 3'd0) begin
            reps[k]   = '{mod: lit_mod, key: lit_key, last: 1'b0};
            reps[k+1] = '{mod: 8'h00, key: 8'h00, last: 1'b1};
          end
        end
        for (int i = 0; i < n; i++) awaited_reports.push_back(reps[i]);
      end
      if (out_pop && !out_empty) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected report mod=%02h key=%02h last=%0d, none awaited",
                   $time, out_modifier_bits, out_key_usage, out_last);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (out_modifier_bits !== want.mod || out_key_usage !== want.key ||
              out_last !== want.last) begin
            $display("%0t: expected mod=%02h key=%02h last=%0d, got mod=%02h key=%02h last=%0d",
                     $time, want.mod, want.key, want.last,
                     out_modifier_bits, out_key_usage, out_last);
            mismatches++;
          end
        end
      end
    end
  end

  // Host side: mostly popping, short and long stalls, calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      if (pop_calm > 0) begin
        pop_calm <= pop_calm - 1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: pop_hold <= $urandom_range(1, 3);
          4:          pop_hold <= $urandom_range(10, 40);
          5:          pop_calm <= $urandom_range(20, 60);
          default:    pop_hold <= 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (push_calm > 0) begin
      push_calm--;
      return 0;
    end
    if (r < 5) push_calm = $urandom_range(8, 20);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic stim_t pick_item();
    stim_t s;
    int    r;
    s      = '0;
    s.op   = OP_CHAR;
    s.code = 8'($urandom_range(0, 255));
    s.leds = 8'($urandom_range(0, 255));
    r      = $urandom_range(0, 99);
    if (r < 10) begin
      s.op = OP_LED;
    end else if (r < 35) begin
      s.code = 8'($urandom_range(8'h61, 8'h7A));
    end else if (r < 55) begin
      s.code = 8'($urandom_range(8'h41, 8'h5A));
    end else if (r < 62) begin
      s.code = 8'($urandom_range(8'h30, 8'h39));
    end else if (r < 72) begin
      s.code = 8'($urandom_range(8'h20, 8'h7F));
    end else if (r < 77) begin
      s.code = 8'($urandom_range(8'h80, 8'h87));
    end else if (r < 84) begin
      case ($urandom_range(0, 3))
        0:       s.code = 8'($urandom_range(8'hB0, 8'hB3));
        1:       s.code = 8'($urandom_range(8'hC1, 8'hCD));
        2:       s.code = 8'($urandom_range(8'hD1, 8'hD5));
        default: s.code = 8'($urandom_range(8'hD7, 8'hDA));
      endcase
    end else if (r < 92) begin
      s.code = 8'($urandom_range(0, 255));
    end else if (r < 96) begin
      s.code = prefix_model;
    end else begin
      s.code = 8'($urandom_range(8'h00, 8'h1F));
    end
    return s;
  endfunction

  task automatic type_item(input stim_t s);
    int gap;
    in_push      <= 1'b1;
    in_op        <= s.op;
    in_char_code <= s.code;
    in_led_bits  <= s.leds;
    lit_valid    <= s.lit;
    lit_n        <= s.lit_n;
    lit_mod      <= s.lit_mod;
    lit_key      <= s.lit_key;
    do @(posedge clk); while (in_full);
    gap = pick_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain: hold off until every awaited report has arrived, then let the core settle
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_prefix(input logic [7:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [7:0] settings [0:3];
    dir_rows = '{
      '{OP_CHAR, 8'h61, 8'h00, 1'b1, 3'd2, 8'h00, 8'h04},
      '{OP_CHAR, 8'h7A, 8'hFF, 1'b1, 3'd2, 8'h00, 8'h1D},
      '{OP_CHAR, 8'h41, 8'h00, 1'b1, 3'd4, 8'h00, 8'h04},
      '{OP_CHAR, 8'h5A, 8'hFF, 1'b1, 3'd4, 8'h00, 8'h1D},
      '{OP_CHAR, 8'h31, 8'h00, 1'b1, 3'd2, 8'h00, 8'h1E},
      '{OP_CHAR, 8'h39, 8'hFF, 1'b1, 3'd2, 8'h00, 8'h26},
      '{OP_CHAR, 8'h30, 8'h00, 1'b1, 3'd2, 8'h00, 8'h27},
      '{OP_CHAR, 8'h00, 8'hFF, 1'b1, 3'd2, 8'h00, 8'h00},
      '{OP_CHAR, 8'hFF, 8'h00, 1'b1, 3'd2, 8'h00, 8'h00},
      '{OP_CHAR, 8'hE1, 8'hFF, 1'b1, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h80, 8'h00, 1'b1, 3'd2, 8'h01, 8'h00},
      '{OP_CHAR, 8'h87, 8'hFF, 1'b1, 3'd2, 8'h80, 8'h00},
      '{OP_CHAR, 8'hB0, 8'h00, 1'b1, 3'd2, 8'h00, 8'h28},
      '{OP_CHAR, 8'hDA, 8'hFF, 1'b1, 3'd2, 8'h00, 8'h52},
      '{OP_CHAR, 8'h21, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h7F, 8'hFF, 1'b0, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h20, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h1F, 8'hFF, 1'b1, 3'd2, 8'h00, 8'h00},
      '{OP_LED,  8'hFF, 8'h02, 1'b1, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h61, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h5A, 8'hFF, 1'b0, 3'd0, 8'h00, 8'h00},
      '{OP_LED,  8'h00, 8'hFD, 1'b1, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h7E, 8'h00, 1'b0, 3'd0, 8'h00, 8'h00},
      '{OP_LED,  8'hFF, 8'hFF, 1'b1, 3'd0, 8'h00, 8'h00},
      '{OP_CHAR, 8'h6D, 8'hFF, 1'b0, 3'd0, 8'h00, 8'h00}
    };
    settings = '{8'h00, 8'hFF, 8'h61, 8'h00};
    settings[3] = 8'($urandom_range(0, 255));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) type_item(dir_rows[i]);

    foreach (settings[p]) begin
      write_prefix(settings[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) type_item(pick_item());
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/a2h_pkg.sv
hw/rtl/a2h_front.sv
hw/rtl/a2h_queue.sv
hw/rtl/a2h_back.sv
hw/rtl/ascii_to_hid_key_report_encoder_core.sv
dv/tb.sv
